>>> rtl/pkcs7_pu_pkg.sv
`default_nettype none

package pkcs7_pu_pkg;

    localparam int BYTE_W          = 8;
    localparam int BLOCK_BYTES_DEF = 16;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              message_end;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_has_byte;
        logic              out_last;
        logic              status;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_CHECK,
        ST_SWEEP
    } fsm_state_t;

    // what the output register loads
    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_PASS,
        OUT_OLDEST,
        OUT_PAD,
        OUT_BARE_OK,
        OUT_ERROR
    } out_sel_t;

    typedef struct packed {
        out_sel_t out_sel;
        logic     out_last;
        logic     push_byte;
        logic     pos_step;
        logic     pad_start;
        logic     pad_step;
        logic     sweep_start;
        logic     sweep_shift;
        logic     msg_clear;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic unpad_mode;
        logic win_full;
        logic check_ok;
        logic keep_zero;
        logic pad_last;
        logic sweep_emit;
        logic sweep_last;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/pkcs7_pu_ctrl.sv
`default_nettype none

module pkcs7_pu_ctrl
    import pkcs7_pu_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     s_has_byte,
    input  wire logic     s_message_end,
    output logic          s_ready,
    input  wire stat_t    stat,
    output cmd_t          cmd
);

    fsm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = stat.slot_free;
                if (s_valid && stat.slot_free) begin
                    if (!stat.unpad_mode) begin
                        if (s_has_byte) begin
                            cmd.out_sel  = OUT_PASS;
                            cmd.pos_step = 1'b1;
                        end
                        if (s_message_end) begin
                            cmd.pad_start = 1'b1;
                            state_next    = ST_PAD;
                        end
                    end else begin
                        if (s_has_byte) begin
                            cmd.push_byte = 1'b1;
                            // full window: the oldest byte leaves as the new one enters
                            if (stat.win_full) begin
                                cmd.out_sel = OUT_OLDEST;
                            end
                        end
                        if (s_message_end) begin
                            state_next = ST_CHECK;
                        end
                    end
                end
            end
            ST_PAD: begin
                if (stat.slot_free) begin
                    cmd.out_sel  = OUT_PAD;
                    cmd.out_last = stat.pad_last;
                    cmd.pad_step = 1'b1;
                    if (stat.pad_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CHECK: begin
                if (!stat.check_ok) begin
                    if (stat.slot_free) begin
                        cmd.out_sel   = OUT_ERROR;
                        cmd.msg_clear = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else if (stat.keep_zero) begin
                    if (stat.slot_free) begin
                        cmd.out_sel   = OUT_BARE_OK;
                        cmd.msg_clear = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    cmd.sweep_start = 1'b1;
                    state_next      = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (!stat.sweep_emit) begin
                    // entry not part of this message, just shift past it
                    cmd.sweep_shift = 1'b1;
                end else if (stat.slot_free) begin
                    cmd.out_sel     = OUT_OLDEST;
                    cmd.out_last    = stat.sweep_last;
                    cmd.sweep_shift = 1'b1;
                    if (stat.sweep_last) begin
                        cmd.msg_clear = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/pkcs7_pu_dpath.sv
`default_nettype none

module pkcs7_pu_dpath
    import pkcs7_pu_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_wr_en,
    input  wire logic      cfg_wr_data,
    input  wire in_item_t  s_item,
    input  wire cmd_t      cmd,
    output stat_t          stat,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    localparam int PW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int FW = $clog2(BLOCK_BYTES + 1);
    localparam logic [FW-1:0]     N_F     = FW'(BLOCK_BYTES);
    localparam logic [PW-1:0]     POS_MAX = PW'(BLOCK_BYTES - 1);
    localparam logic [BYTE_W-1:0] N_B     = BYTE_W'(BLOCK_BYTES);

    logic                mode_reg, mode_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [BYTE_W-1:0]   win_reg [BLOCK_BYTES];
    logic [BYTE_W-1:0]   win_next [BLOCK_BYTES];
    logic [FW-1:0]       rem_reg, rem_next;
    logic [BYTE_W-1:0]   pad_val_reg, pad_val_next;
    logic [FW-1:0]       j_reg, j_next;
    logic [FW-1:0]       start_reg, start_next;
    logic [FW-1:0]       last_idx_reg, last_idx_next;
    out_item_t           out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [PW-1:0]       pos_inc, pos_eff;
    logic [FW-1:0]       plen;
    logic [BYTE_W-1:0]   pad_len, fill_b;
    logic                mism;
    logic                win_full;
    logic                slot_free;

    assign slot_free = !out_valid_reg || m_ready;
    assign win_full  = (fill_reg == N_F);

    // pad-mode position counter
    assign pos_inc = (pos_reg == POS_MAX) ? '0 : pos_reg + 1'b1;
    assign pos_eff = cmd.pos_step ? pos_inc : pos_reg;
    assign plen    = N_F - FW'(pos_eff);

    always_comb begin
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        fill_next    = fill_reg;
        rem_next     = rem_reg;
        pad_val_next = pad_val_reg;
        if (cmd.pos_step) begin
            pos_next = pos_inc;
        end
        if (cmd.pad_start) begin
            pos_next     = '0;
            rem_next     = plen;
            pad_val_next = BYTE_W'(plen);
        end
        if (cmd.pad_step) begin
            rem_next = rem_reg - 1'b1;
        end
        if (cmd.push_byte && !win_full) begin
            fill_next = fill_reg + 1'b1;
        end
        if (cmd.msg_clear) begin
            pos_next  = '0;
            fill_next = '0;
        end
        if (cfg_wr_en) begin
            mode_next = cfg_wr_data;
            pos_next  = '0;
            fill_next = '0;
        end
    end

    // tail window: newest byte at the top entry, oldest valid byte leaves at entry 0
    always_comb begin
        win_next = win_reg;
        if (cmd.push_byte || cmd.sweep_shift) begin
            for (int i = 0; i < BLOCK_BYTES - 1; i++) begin
                win_next[i] = win_reg[i + 1];
            end
        end
        if (cmd.push_byte) begin
            win_next[BLOCK_BYTES-1] = s_item.data_byte;
        end
    end

    // padding check over the held bytes
    assign pad_len = win_reg[BLOCK_BYTES-1];
    assign fill_b  = BYTE_W'(fill_reg);

    always_comb begin
        mism = 1'b0;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            if ((BYTE_W'(BLOCK_BYTES - 1 - i) < pad_len) && (win_reg[i] != pad_len)) begin
                mism = 1'b1;
            end
        end
    end

    always_comb begin
        j_next        = j_reg;
        start_next    = start_reg;
        last_idx_next = last_idx_reg;
        if (cmd.sweep_start) begin
            j_next        = '0;
            start_next    = N_F - fill_reg;
            last_idx_next = N_F - FW'(pad_len) - 1'b1;
        end else if (cmd.sweep_shift) begin
            j_next = j_reg + 1'b1;
        end
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (cmd.out_sel)
            OUT_NONE: begin
                out_next = out_reg;
            end
            OUT_PASS: begin
                out_next       = '{out_byte: s_item.data_byte, out_has_byte: 1'b1,
                                   out_last: 1'b0, status: 1'b0};
                out_valid_next = 1'b1;
            end
            OUT_OLDEST: begin
                out_next       = '{out_byte: win_reg[0], out_has_byte: 1'b1,
                                   out_last: cmd.out_last, status: 1'b0};
                out_valid_next = 1'b1;
            end
            OUT_PAD: begin
                out_next       = '{out_byte: pad_val_reg, out_has_byte: 1'b1,
                                   out_last: cmd.out_last, status: 1'b0};
                out_valid_next = 1'b1;
            end
            OUT_BARE_OK: begin
                out_next       = '{out_byte: '0, out_has_byte: 1'b0,
                                   out_last: 1'b1, status: 1'b0};
                out_valid_next = 1'b1;
            end
            OUT_ERROR: begin
                out_next       = '{out_byte: '0, out_has_byte: 1'b0,
                                   out_last: 1'b1, status: 1'b1};
                out_valid_next = 1'b1;
            end
            default: begin
                out_next = out_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg      <= win_next;
        rem_reg      <= rem_next;
        pad_val_reg  <= pad_val_next;
        j_reg        <= j_next;
        start_reg    <= start_next;
        last_idx_reg <= last_idx_next;
        out_reg      <= out_next;
    end

    always_comb begin
        stat.slot_free  = slot_free;
        stat.unpad_mode = mode_reg;
        stat.win_full   = win_full;
        stat.check_ok   = (fill_reg != '0) && (pad_len != '0) && (pad_len <= N_B)
                          && (pad_len <= fill_b) && !mism;
        stat.keep_zero  = (pad_len == fill_b);
        stat.pad_last   = (rem_reg == FW'(1));
        stat.sweep_emit = (j_reg >= start_reg);
        stat.sweep_last = (j_reg == last_idx_reg);
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_sel != OUT_NONE) |-> slot_free)
        else $error("result loaded while previous one not taken");

    a_release_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push_byte && win_full) |-> (cmd.out_sel == OUT_OLDEST))
        else $error("byte pushed into full window without release");

    a_sweep_after_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep_start |-> (stat.check_ok && !stat.keep_zero && mode_reg))
        else $error("sweep started without passed padding check");
`endif

endmodule

`default_nettype wire

>>> rtl/pkcs7_pad_unpad_stream_core.sv
`default_nettype none

// PKCS#7 padder / unpadder for a byte stream, BLOCK_BYTES-byte blocks.
// Input channel s_*: one item per transfer, at most one byte plus an end marker.
// Result channel m_*: one byte (or a bare end/error result) per transfer.
// cfg_wr_en / cfg_wr_data: selects pad (0) or unpad (1); write only while idle,
// a write drops any message in progress.
// Pass-through bytes reach m_valid the next cycle, one per cycle unless stalled.
// Pad mode: message end appends 1..BLOCK_BYTES pad bytes, one per cycle while the
// output register is free; input is held off until the last one is loaded.
// Unpad mode: the newest BLOCK_BYTES bytes are held back; at message end a check
// state follows, then a sweep walks the window shift register and releases the
// kept bytes. In either mode a message end holds off the next item until the
// block is back in its idle state.
// An error result (status 1) replaces the kept bytes on bad padding; bytes
// already released are not recalled.
// A single output register separates the channels: a stalled receiver only
// holds off new input once that register is full.
// Reset selects pad mode, zeroes pos/fill and empties the output register.

module pkcs7_pad_unpad_stream_core
    import pkcs7_pu_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_wr_en,
    input  wire logic      cfg_wr_data,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    cmd_t  cmd;
    stat_t stat;

    pkcs7_pu_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_has_byte    (s_item.has_byte),
        .s_message_end (s_item.message_end),
        .s_ready       (s_ready),
        .stat          (stat),
        .cmd           (cmd)
    );

    pkcs7_pu_dpath #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_item      (s_item),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

`default_nettype wire
